### hdl/sli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_pkg
// Shared types and widths for the segment/line intersection core.
// ----------------------------------------------------------------------------
package sli_pkg;

  // Magnitude of a cross product of two 33-bit differences
  localparam int MagW   = 67;
  // Quotient bits produced by the divider chain
  localparam int QuoW   = 33;
  // Lanes in the divider: t, point x, point y
  localparam int Lanes  = 3;
  localparam int LaneT  = 0;
  localparam int LaneX  = 1;
  localparam int LaneY  = 2;

  typedef enum logic {
    OP_RAY     = 1'b0,
    OP_SEGMENT = 1'b1
  } sli_op_e;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] first_start_x;
    logic signed [31:0] first_start_y;
    logic signed [31:0] first_far_x;
    logic signed [31:0] first_far_y;
    logic signed [31:0] second_start_x;
    logic signed [31:0] second_start_y;
    logic signed [31:0] second_end_x;
    logic signed [31:0] second_end_y;
  } sli_in_t;

  typedef struct packed {
    logic               hit;
    logic [31:0]        hit_param;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } sli_out_t;

  // Transaction state carried from cell to cell along the divider chain
  typedef struct packed {
    logic [MagW-1:0]             den;
    logic [Lanes-1:0][MagW-1:0]  rem;
    logic [Lanes-1:0][QuoW-1:0]  nq;
    logic [Lanes-1:0]            sat;
    logic                        hit;
    logic                        neg_x;
    logic                        neg_y;
    logic signed [31:0]          px;
    logic signed [31:0]          py;
  } sli_div_t;

endpackage

### hdl/sli_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_div_cell
// One restoring division step for all three lanes; registered output.
// ----------------------------------------------------------------------------
module sli_div_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  sli_pkg::sli_div_t data_i,
  output logic              valid_o,
  output sli_pkg::sli_div_t data_o
);
  import sli_pkg::*;

  logic     valid_q;
  sli_div_t data_d, data_q;

  // Shift in the next numerator bit, subtract the divisor when it fits
  always_comb begin
    logic [MagW:0] trial;
    logic          ge;
    data_d = data_i;
    for (int l = 0; l < Lanes; l++) begin
      trial = {data_i.rem[l], data_i.nq[l][QuoW-1]};
      ge    = (trial >= {1'b0, data_i.den});
      if (ge) begin
        trial = trial - {1'b0, data_i.den};
      end
      data_d.rem[l] = trial[MagW-1:0];
      data_d.nq[l]  = {data_i.nq[l][QuoW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### hdl/sli_geom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_geom
// Cross products, parallel and range tests, and divider operand setup.
// ----------------------------------------------------------------------------
module sli_geom #(
  parameter int FRACTION_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  sli_pkg::sli_in_t  data_i,
  input  logic [31:0]       threshold_i,
  output logic              valid_o,
  output sli_pkg::sli_div_t data_o
);
  import sli_pkg::*;

  localparam int NumW = MagW + QuoW;          // point numerator width
  localparam int TshW = MagW + FRACTION_BITS; // t numerator width

  logic [7:0] vld_q;

  // Stage A: differences
  logic               a_seg_q;
  logic signed [31:0] a_px_q, a_py_q;
  logic signed [32:0] a_rx_q, a_ry_q, a_sx_q, a_sy_q, a_wx_q, a_wy_q;
  // Stage B: products
  logic               b_seg_q;
  logic signed [31:0] b_px_q, b_py_q;
  logic signed [32:0] b_rx_q, b_ry_q;
  logic signed [65:0] b_d1_q, b_d2_q, b_t1_q, b_t2_q, b_u1_q, b_u2_q;
  // Stage C: cross products
  logic               c_seg_q;
  logic signed [31:0] c_px_q, c_py_q;
  logic signed [32:0] c_rx_q, c_ry_q;
  logic signed [67:0] c_den_q, c_nt_q, c_nu_q;
  // Stage D: sign normalized
  logic               d_seg_q;
  logic signed [31:0] d_px_q, d_py_q;
  logic signed [32:0] d_rx_q, d_ry_q;
  logic signed [67:0] d_den_q, d_nt_q, d_nu_q;
  // Stage E: hit decision
  logic               e_hit_q, e_neg_x_q, e_neg_y_q;
  logic signed [31:0] e_px_q, e_py_q;
  logic [MagW-1:0]    e_den_q, e_nt_q;
  logic [32:0]        e_ax_q, e_ay_q;
  // Stage F: partial products
  logic               f_hit_q, f_neg_x_q, f_neg_y_q;
  logic signed [31:0] f_px_q, f_py_q;
  logic [MagW-1:0]    f_den_q, f_nt_q;
  logic [66:0]        f_xl_q, f_yl_q;
  logic [65:0]        f_xh_q, f_yh_q;
  // Stage G: full numerators
  logic               g_hit_q, g_neg_x_q, g_neg_y_q;
  logic signed [31:0] g_px_q, g_py_q;
  logic [MagW-1:0]    g_den_q;
  logic [TshW-1:0]    g_nt_q;
  logic [NumW-1:0]    g_nx_q, g_ny_q;
  // Stage H: divider load
  sli_div_t           h_q;

  // Combinational helpers
  logic               seg;
  logic signed [32:0] fsx, fsy, ffx, ffy, ssx, ssy, sex, sey;
  logic signed [67:0] den_abs, nt_abs, nu_abs, den_cmp;
  logic               e_hit_d;
  logic [TshW-1:0]    tsh;

  assign seg = (data_i.operation == OP_SEGMENT);
  assign fsx = {data_i.first_start_x[31], data_i.first_start_x};
  assign fsy = {data_i.first_start_y[31], data_i.first_start_y};
  assign ffx = {data_i.first_far_x[31], data_i.first_far_x};
  assign ffy = {data_i.first_far_y[31], data_i.first_far_y};
  assign ssx = {data_i.second_start_x[31], data_i.second_start_x};
  assign ssy = {data_i.second_start_y[31], data_i.second_start_y};
  assign sex = {data_i.second_end_x[31], data_i.second_end_x};
  assign sey = {data_i.second_end_y[31], data_i.second_end_y};

  // Flip signs so the denominator is nonnegative
  assign den_abs = c_den_q[67] ? -c_den_q : c_den_q;
  assign nt_abs  = c_den_q[67] ? -c_nt_q  : c_nt_q;
  assign nu_abs  = c_den_q[67] ? -c_nu_q  : c_nu_q;

  // Parallel test and range tests on the numerators
  assign den_cmp = d_den_q;
  assign e_hit_d = (den_cmp != '0)
                && (d_den_q[MagW-1:0] >= {{(MagW-32){1'b0}}, threshold_i})
                && !d_nt_q[67] && (!d_seg_q || d_nt_q <= den_cmp)
                && !d_nu_q[67] && (d_nu_q <= den_cmp);

  assign tsh = {g_nt_q[TshW-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[6:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // A
      a_seg_q <= seg;
      a_px_q  <= data_i.first_start_x;
      a_py_q  <= data_i.first_start_y;
      a_rx_q  <= seg ? ffx - fsx : ffx;
      a_ry_q  <= seg ? ffy - fsy : ffy;
      a_sx_q  <= sex - ssx;
      a_sy_q  <= sey - ssy;
      a_wx_q  <= ssx - fsx;
      a_wy_q  <= ssy - fsy;
      // B
      b_seg_q <= a_seg_q;
      b_px_q  <= a_px_q;
      b_py_q  <= a_py_q;
      b_rx_q  <= a_rx_q;
      b_ry_q  <= a_ry_q;
      b_d1_q  <= a_rx_q * a_sy_q;
      b_d2_q  <= a_ry_q * a_sx_q;
      b_t1_q  <= a_wx_q * a_sy_q;
      b_t2_q  <= a_wy_q * a_sx_q;
      b_u1_q  <= a_wx_q * a_ry_q;
      b_u2_q  <= a_wy_q * a_rx_q;
      // C
      c_seg_q <= b_seg_q;
      c_px_q  <= b_px_q;
      c_py_q  <= b_py_q;
      c_rx_q  <= b_rx_q;
      c_ry_q  <= b_ry_q;
      c_den_q <= {{2{b_d1_q[65]}}, b_d1_q} - {{2{b_d2_q[65]}}, b_d2_q};
      c_nt_q  <= {{2{b_t1_q[65]}}, b_t1_q} - {{2{b_t2_q[65]}}, b_t2_q};
      c_nu_q  <= {{2{b_u1_q[65]}}, b_u1_q} - {{2{b_u2_q[65]}}, b_u2_q};
      // D
      d_seg_q <= c_seg_q;
      d_px_q  <= c_px_q;
      d_py_q  <= c_py_q;
      d_rx_q  <= c_rx_q;
      d_ry_q  <= c_ry_q;
      d_den_q <= den_abs;
      d_nt_q  <= nt_abs;
      d_nu_q  <= nu_abs;
      // E
      e_hit_q   <= e_hit_d;
      e_neg_x_q <= d_rx_q[32];
      e_neg_y_q <= d_ry_q[32];
      e_px_q    <= d_px_q;
      e_py_q    <= d_py_q;
      e_den_q   <= d_den_q[MagW-1:0];
      e_nt_q    <= d_nt_q[MagW-1:0];
      e_ax_q    <= d_rx_q[32] ? 33'(-d_rx_q) : 33'(d_rx_q);
      e_ay_q    <= d_ry_q[32] ? 33'(-d_ry_q) : 33'(d_ry_q);
      // F: split the numerator in two halves for narrow multipliers
      f_hit_q   <= e_hit_q;
      f_neg_x_q <= e_neg_x_q;
      f_neg_y_q <= e_neg_y_q;
      f_px_q    <= e_px_q;
      f_py_q    <= e_py_q;
      f_den_q   <= e_den_q;
      f_nt_q    <= e_nt_q;
      f_xl_q    <= e_nt_q[33:0] * e_ax_q;
      f_yl_q    <= e_nt_q[33:0] * e_ay_q;
      f_xh_q    <= e_nt_q[66:34] * e_ax_q;
      f_yh_q    <= e_nt_q[66:34] * e_ay_q;
      // G
      g_hit_q   <= f_hit_q;
      g_neg_x_q <= f_neg_x_q;
      g_neg_y_q <= f_neg_y_q;
      g_px_q    <= f_px_q;
      g_py_q    <= f_py_q;
      g_den_q   <= f_den_q;
      g_nt_q    <= {f_nt_q, {FRACTION_BITS{1'b0}}};
      g_nx_q    <= {f_xh_q, 34'd0} + {{(NumW-67){1'b0}}, f_xl_q};
      g_ny_q    <= {f_yh_q, 34'd0} + {{(NumW-67){1'b0}}, f_yl_q};
      // H: load remainders; an oversize leading part saturates the lane
      h_q.den          <= g_den_q;
      h_q.hit          <= g_hit_q;
      h_q.neg_x        <= g_neg_x_q;
      h_q.neg_y        <= g_neg_y_q;
      h_q.px           <= g_px_q;
      h_q.py           <= g_py_q;
      h_q.rem[LaneT]   <= MagW'(tsh[TshW-1:QuoW]);
      h_q.nq[LaneT]    <= tsh[QuoW-1:0];
      h_q.sat[LaneT]   <= (MagW'(tsh[TshW-1:QuoW]) >= g_den_q);
      h_q.rem[LaneX]   <= g_nx_q[NumW-1:QuoW];
      h_q.nq[LaneX]    <= g_nx_q[QuoW-1:0];
      h_q.sat[LaneX]   <= (g_nx_q[NumW-1:QuoW] >= g_den_q);
      h_q.rem[LaneY]   <= g_ny_q[NumW-1:QuoW];
      h_q.nq[LaneY]    <= g_ny_q[QuoW-1:0];
      h_q.sat[LaneY]   <= (g_ny_q[NumW-1:QuoW] >= g_den_q);
    end
  end

  assign valid_o = vld_q[7];
  assign data_o  = h_q;

endmodule

### hdl/segment_line_intersector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_line_intersector_core
// 2D ray/segment and segment/segment intersection in signed fixed point.
// ----------------------------------------------------------------------------
// Pipeline: 8 geometry stages, 33 divider cells of one quotient bit each,
// and 1 output register.
// Throughput: one transaction per cycle; the whole pipeline holds while a
// result waits at the output.
// Reset: clears all valid bits and sets the parallel threshold to 43.
module segment_line_intersector_core #(
  parameter int FRACTION_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sli_pkg::sli_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sli_pkg::sli_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [31:0]       cfg_data_i
);
  import sli_pkg::*;

  localparam logic [31:0] ThrReset = 32'd43;

  logic        en;
  logic [31:0] thr_q;
  logic        out_valid_q;
  sli_out_t    out_q, out_d;

  logic     [QuoW:0] cvalid;
  sli_div_t [QuoW:0] cdata;

  // Advance everything unless a result is blocked at the output
  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  sli_geom #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_geom (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .data_i     (in_data_i),
    .threshold_i(thr_q),
    .valid_o    (cvalid[0]),
    .data_o     (cdata[0])
  );

  // Divider chain, one quotient bit per cell
  for (genvar g = 0; g < QuoW; g++) begin : g_cell
    sli_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(cvalid[g]),
      .data_i (cdata[g]),
      .valid_o(cvalid[g+1]),
      .data_o (cdata[g+1])
    );
  end

  // Saturate t and form the point per axis
  always_comb begin
    sli_div_t           r;
    logic [33:0]        mx, my;
    logic signed [35:0] sx, sy;
    r  = cdata[QuoW];
    mx = r.sat[LaneX] ? 34'h2_0000_0000 : {1'b0, r.nq[LaneX]};
    my = r.sat[LaneY] ? 34'h2_0000_0000 : {1'b0, r.nq[LaneY]};
    sx = {{4{r.px[31]}}, r.px} + (r.neg_x ? -{2'b00, mx} : {2'b00, mx});
    sy = {{4{r.py[31]}}, r.py} + (r.neg_y ? -{2'b00, my} : {2'b00, my});
    out_d = '0;
    if (r.hit) begin
      out_d.hit       = 1'b1;
      out_d.hit_param = (r.sat[LaneT] || r.nq[LaneT][QuoW-1]) ? 32'hFFFF_FFFF
                                                              : r.nq[LaneT][31:0];
      if (sx > 36'sh0_7FFF_FFFF) begin
        out_d.point_x = 32'sh7FFF_FFFF;
      end else if (sx < -36'sh0_8000_0000) begin
        out_d.point_x = 32'sh8000_0000;
      end else begin
        out_d.point_x = sx[31:0];
      end
      if (sy > 36'sh0_7FFF_FFFF) begin
        out_d.point_y = 32'sh7FFF_FFFF;
      end else if (sy < -36'sh0_8000_0000) begin
        out_d.point_y = 32'sh8000_0000;
      end else begin
        out_d.point_y = sy[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= cvalid[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
